/* rtl/itw_pkg.sv */
// Package: shared types and constants for the two-wire transfer master.
`timescale 1ns / 1ps

package itw_pkg;

  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned OPCODE_BITS = 7;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned STATUS_W    = 3;

  // Acknowledge codes sampled from the target
  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_WAIT  = 3'd2;
  localparam logic [2:0] ACK_FAULT = 3'd4;

  // Status codes reported with done
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PARITY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OTHER   = 3'd4;

  localparam logic [7:0] RETRY_RESET = 8'd100;

  // Link phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_OPC   = 4'd2,
    PH_TURN  = 4'd3,
    PH_ACK   = 4'd4,
    PH_WTURN = 4'd5,
    PH_WDATA = 4'd6,
    PH_WPAR  = 4'd7,
    PH_WTAIL = 4'd8,
    PH_RDATA = 4'd9,
    PH_RPAR  = 4'd10,
    PH_RTAIL = 4'd11,
    PH_ETAIL = 4'd12
  } phase_e;

  // Transfer state carried from one bit period to the next
  typedef struct packed {
    phase_e                 phase;
    logic [CNT_W-1:0]       bit_count;
    logic [DATA_BITS-1:0]   shift_word;
    logic                   parity_acc;
    logic [2:0]             ack_bits;
    logic [7:0]             attempt_count;
    logic [OPCODE_BITS-1:0] held_opcode;
    logic                   held_mode;
    logic [DATA_BITS-1:0]   held_write_word;
  } state_t;

  // One result item
  typedef struct packed {
    logic                 clock_pulse;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic [STATUS_W-1:0]  status;
    logic [DATA_BITS-1:0] rx_word;
  } result_t;

endpackage

/* rtl/itw_core.sv */
// Bit period logic: next link state and the result item for one input item.
`timescale 1ns / 1ps

module itw_core (
  input  itw_pkg::state_t                   state_i,
  input  logic                              start_req_i,
  input  logic                              mode_i,
  input  logic [itw_pkg::OPCODE_BITS-1:0]   opcode_i,
  input  logic [itw_pkg::DATA_BITS-1:0]     write_data_i,
  input  logic                              sda_sample_i,
  input  logic [7:0]                        retry_limit_i,
  output itw_pkg::state_t                   state_o,
  output itw_pkg::result_t                  res_o
);

  localparam logic [itw_pkg::CNT_W-1:0] OPC_LAST  = itw_pkg::CNT_W'(itw_pkg::OPCODE_BITS - 1);
  localparam logic [itw_pkg::CNT_W-1:0] DATA_LAST = itw_pkg::CNT_W'(itw_pkg::DATA_BITS - 1);
  localparam logic [itw_pkg::CNT_W-1:0] ACK_LAST  = itw_pkg::CNT_W'(2);
  localparam logic [itw_pkg::CNT_W-1:0] CNT_ONE   = itw_pkg::CNT_W'(1);

  logic [7:0] opc_ext;
  logic [2:0] ack_new;

  assign opc_ext = 8'(state_i.held_opcode);
  assign ack_new = state_i.ack_bits | (3'(sda_sample_i) << state_i.bit_count[1:0]);

  // One bit period of the frame sequencer
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    res_o.busy_res = 1'b1;
    case (state_i.phase)
      itw_pkg::PH_IDLE: begin
        res_o.sda_level = 1'b1;
        res_o.sda_drive = 1'b1;
        if (!start_req_i) begin
          res_o.busy_res = 1'b0;
        end else begin
          state_o.held_mode       = mode_i;
          state_o.held_opcode     = opcode_i;
          state_o.held_write_word = write_data_i;
          state_o.attempt_count   = 8'd1;
          state_o.phase           = itw_pkg::PH_OPC;
          state_o.bit_count       = '0;
          res_o.clock_pulse       = 1'b1;
        end
      end
      itw_pkg::PH_START: begin
        res_o.clock_pulse = 1'b1;
        res_o.sda_level   = 1'b1;
        res_o.sda_drive   = 1'b1;
        state_o.phase     = itw_pkg::PH_OPC;
        state_o.bit_count = '0;
      end
      itw_pkg::PH_OPC: begin
        res_o.clock_pulse = 1'b1;
        res_o.sda_drive   = 1'b1;
        res_o.sda_level   = opc_ext[state_i.bit_count[2:0]];
        if (state_i.bit_count >= OPC_LAST) begin
          state_o.phase     = itw_pkg::PH_TURN;
          state_o.bit_count = '0;
        end else begin
          state_o.bit_count = state_i.bit_count + 1'b1;
        end
      end
      itw_pkg::PH_TURN: begin
        res_o.clock_pulse = 1'b1;
        state_o.phase     = itw_pkg::PH_ACK;
        state_o.bit_count = '0;
        state_o.ack_bits  = '0;
      end
      itw_pkg::PH_ACK: begin
        res_o.clock_pulse = 1'b1;
        state_o.ack_bits  = ack_new;
        if (state_i.bit_count >= ACK_LAST) begin
          state_o.bit_count = '0;
          if (ack_new == itw_pkg::ACK_OK) begin
            if (state_i.held_mode) begin
              state_o.phase = itw_pkg::PH_WTURN;
            end else begin
              state_o.phase      = itw_pkg::PH_RDATA;
              state_o.shift_word = '0;
              state_o.parity_acc = 1'b0;
            end
          end else begin
            state_o.phase = itw_pkg::PH_ETAIL;
          end
        end else begin
          state_o.bit_count = state_i.bit_count + 1'b1;
        end
      end
      itw_pkg::PH_WTURN: begin
        res_o.clock_pulse  = 1'b1;
        state_o.phase      = itw_pkg::PH_WDATA;
        state_o.bit_count  = '0;
        state_o.shift_word = state_i.held_write_word;
        state_o.parity_acc = 1'b0;
      end
      itw_pkg::PH_WDATA: begin
        res_o.clock_pulse  = 1'b1;
        res_o.sda_drive    = 1'b1;
        res_o.sda_level    = state_i.shift_word[0];
        state_o.parity_acc = state_i.parity_acc ^ state_i.shift_word[0];
        state_o.shift_word = state_i.shift_word >> 1;
        if (state_i.bit_count >= DATA_LAST) begin
          state_o.phase     = itw_pkg::PH_WPAR;
          state_o.bit_count = '0;
        end else begin
          state_o.bit_count = state_i.bit_count + 1'b1;
        end
      end
      itw_pkg::PH_WPAR: begin
        res_o.clock_pulse = 1'b1;
        res_o.sda_drive   = 1'b1;
        res_o.sda_level   = state_i.parity_acc;
        state_o.phase     = itw_pkg::PH_WTAIL;
      end
      itw_pkg::PH_WTAIL: begin
        res_o.clock_pulse = 1'b1;
        res_o.sda_drive   = 1'b1;
        res_o.done_res    = 1'b1;
        res_o.status      = itw_pkg::ST_OK;
        state_o.phase     = itw_pkg::PH_IDLE;
      end
      itw_pkg::PH_RDATA: begin
        res_o.clock_pulse  = 1'b1;
        state_o.parity_acc = state_i.parity_acc ^ sda_sample_i;
        state_o.shift_word = {sda_sample_i, state_i.shift_word[itw_pkg::DATA_BITS-1:1]};
        if (state_i.bit_count >= DATA_LAST) begin
          state_o.phase     = itw_pkg::PH_RPAR;
          state_o.bit_count = '0;
        end else begin
          state_o.bit_count = state_i.bit_count + 1'b1;
        end
      end
      itw_pkg::PH_RPAR: begin
        res_o.clock_pulse  = 1'b1;
        state_o.parity_acc = state_i.parity_acc ^ sda_sample_i;
        state_o.phase      = itw_pkg::PH_RTAIL;
        state_o.bit_count  = '0;
      end
      itw_pkg::PH_RTAIL: begin
        res_o.clock_pulse = 1'b1;
        res_o.sda_drive   = 1'b1;
        if (state_i.bit_count == '0) begin
          state_o.bit_count = CNT_ONE;
        end else begin
          res_o.done_res    = 1'b1;
          res_o.status      = state_i.parity_acc ? itw_pkg::ST_PARITY : itw_pkg::ST_OK;
          res_o.rx_word     = state_i.shift_word;
          state_o.phase     = itw_pkg::PH_IDLE;
          state_o.bit_count = '0;
        end
      end
      itw_pkg::PH_ETAIL: begin
        // Two trailing periods hold the last opcode level
        res_o.clock_pulse = 1'b1;
        res_o.sda_drive   = 1'b1;
        res_o.sda_level   = opc_ext[OPC_LAST[2:0]];
        if (state_i.bit_count == '0) begin
          state_o.bit_count = CNT_ONE;
        end else begin
          state_o.bit_count = '0;
          if (state_i.ack_bits == itw_pkg::ACK_WAIT &&
              state_i.attempt_count < retry_limit_i) begin
            state_o.attempt_count = state_i.attempt_count + 8'd1;
            state_o.phase         = itw_pkg::PH_START;
          end else begin
            res_o.done_res = 1'b1;
            state_o.phase  = itw_pkg::PH_IDLE;
            if (state_i.ack_bits == itw_pkg::ACK_WAIT) begin
              res_o.status = itw_pkg::ST_TIMEOUT;
            end else if (state_i.ack_bits == itw_pkg::ACK_FAULT) begin
              res_o.status = itw_pkg::ST_FAULT;
            end else begin
              res_o.status = itw_pkg::ST_OTHER;
            end
          end
        end
      end
      default: begin
        res_o.busy_res  = 1'b0;
        res_o.sda_level = 1'b1;
        res_o.sda_drive = 1'b1;
        state_o.phase   = itw_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

/* rtl/itw_out_reg.sv */
// Result register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps

module itw_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  itw_pkg::result_t res_i,
  input  logic             out_ready_i,
  output logic             can_load_o,
  output logic             out_valid_o,
  output itw_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  itw_pkg::result_t res_q;

  // Free when empty or drained this cycle
  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/isp_two_wire_transfer_master_top.sv */
// Top level: two-wire serial transfer master, one bit period per item.
`timescale 1ns / 1ps

// Usage:
//   Each input item is one serial bit period. With start_req_i high while idle,
//   the master sends a start bit, the opcode LSB first, a turnaround, reads a
//   3-bit acknowledge and then moves the 32-bit word (write or read) with even
//   parity. A WAIT acknowledge repeats the frame up to retry_limit attempts.
//   Every input item yields exactly one result item describing the line for
//   that period (clock pulse, data level and drive, busy, done, status, data).
//   The result of an item is registered and appears in the cycle after acceptance.
//   Throughput: one item per cycle while the receiver keeps up; the link state
//   and the result register both update in the accept cycle, so the sequencer itself never holds off input.
//   When the receiver stalls, the result register holds its item and
//   in_ready_o drops until the item is taken; nothing is lost.
//   cfg_we_i writes retry_limit from cfg_data_i; write only while idle.
//   Reset: link returns to idle, counters clear, retry_limit becomes 100,
//   and no result is pending.

module isp_two_wire_transfer_master_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              start_req_i,
  input  logic                              mode_i,
  input  logic [itw_pkg::OPCODE_BITS-1:0]   opcode_i,
  input  logic [itw_pkg::DATA_BITS-1:0]     write_data_i,
  input  logic                              sda_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              clock_pulse_o,
  output logic                              sda_level_o,
  output logic                              sda_drive_o,
  output logic                              busy_res_o,
  output logic                              done_res_o,
  output logic [itw_pkg::STATUS_W-1:0]      status_o,
  output logic [itw_pkg::DATA_BITS-1:0]     rx_word_o
);

  itw_pkg::state_t  state_q, state_d;
  itw_pkg::result_t step_res, out_res;
  logic [7:0]       retry_limit_q;
  logic             in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= itw_pkg::RETRY_RESET;
    end else if (cfg_we_i) begin
      retry_limit_q <= cfg_data_i;
    end
  end

  // Link state advances once per accepted item; all zero is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  itw_core u_core (
    .state_i       (state_q),
    .start_req_i   (start_req_i),
    .mode_i        (mode_i),
    .opcode_i      (opcode_i),
    .write_data_i  (write_data_i),
    .sda_sample_i  (sda_sample_i),
    .retry_limit_i (retry_limit_q),
    .state_o       (state_d),
    .res_o         (step_res)
  );

  itw_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .res_i       (step_res),
    .out_ready_i (out_ready_i),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign clock_pulse_o = out_res.clock_pulse;
  assign sda_level_o   = out_res.sda_level;
  assign sda_drive_o   = out_res.sda_drive;
  assign busy_res_o    = out_res.busy_res;
  assign done_res_o    = out_res.done_res;
  assign status_o      = out_res.status;
  assign rx_word_o     = out_res.rx_word;

  // A finished transfer is always reported as busy on its last period
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done without busy");

  // Status and read word are zero except on the done period
  a_status_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> (status_o == itw_pkg::ST_OK && rx_word_o == '0))
    else $error("status or data outside done");

  // A transfer in flight has counted at least one attempt
  a_attempt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase != itw_pkg::PH_IDLE |-> state_q.attempt_count != 8'd0)
    else $error("active transfer with zero attempts");

  // The link state moves only when an item is accepted
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(state_q))
    else $error("state changed without an item");

endmodule
